/* rtl/core/m68kild_pkg.sv */
package m68kild_pkg;

    // number of instruction words in one item
    localparam int unsigned NUM_WORDS = 7;
    // candidate locations of the move destination extension word (word1..word6)
    localparam int unsigned DST_LANES = 6;

    // line-F opcode classification handed from the decoder to the merge stage
    typedef struct packed {
        logic       fixed;      // length known from the opcode words alone
        logic [1:0] fixed_len;  // that length
        logic       need_ea;    // an effective address follows the two opcode words
        logic [2:0] imm;        // words of an immediate source
    } lf_class_t;

    // opcodes that branch or may change the flow of control
    function automatic logic flow_change(input logic [15:0] op);
        logic hit;
        hit = (op == 16'h007c) || (op == 16'h027c) || (op == 16'h0a7c) ||
              ((op & 16'hffc0) == 16'h40c0) || ((op & 16'hffc0) == 16'h46c0) ||
              ((op & 16'hfff8) == 16'h4848) || (op == 16'h4afc) ||
              ((op & 16'hfff0) == 16'h4e40) || ((op & 16'hfff0) == 16'h4e60) ||
              (op == 16'h4e70) || ((op >= 16'h4e72) && (op <= 16'h4e77)) ||
              ((op & 16'hfffe) == 16'h4e7a) || ((op & 16'hff80) == 16'h4e80) ||
              ((op & 16'hf0f8) == 16'h50c8) || ((op & 16'hf000) == 16'h6000);
        return hit;
    endfunction

endpackage

/* rtl/core/m68k_instruction_length_decoder.sv */
// channel | signals                                  | direction
// --------+------------------------------------------+----------
// in      | in_valid, in_stall, word0 .. word6        | into block
// out     | out_valid, out_stall, length_words,       | out of block
//         | supported, is_branch                      |
//
// one item per cycle while in_stall is low; a result passes the lane stage
// register, then the output register, before it is on the outputs
// rst_n clears only the stage valid flags; no clearing pass is needed
// in_stall rises only when both stages hold items and out_stall is high
module m68k_instruction_length_decoder
    import m68kild_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] word0,
    input  logic [15:0] word1,
    input  logic [15:0] word2,
    input  logic [15:0] word3,
    input  logic [15:0] word4,
    input  logic [15:0] word5,
    input  logic [15:0] word6,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  length_words,
    output logic        supported,
    output logic        is_branch
);

    logic [15:0] words [0:NUM_WORDS-1];
    logic [2:0]  mv_imm;
    logic [5:0]  dst_ea;
    logic [2:0]  src_n;
    logic [2:0]  dst_n [0:DST_LANES-1];
    logic [2:0]  lf_n;
    lf_class_t   lf_cls;

    logic        a_valid_reg;
    logic        a_valid_next;
    logic [3:0]  a_line_reg;
    logic [2:0]  a_src_reg;
    logic [2:0]  a_dst_reg [0:DST_LANES-1];
    logic [2:0]  a_lf_n_reg;
    lf_class_t   a_lf_reg;
    logic        a_branch_reg;

    logic        b_valid_reg;
    logic        b_valid_next;
    logic [3:0]  b_len_reg;
    logic        b_sup_reg;
    logic        b_branch_reg;

    logic        b_adv;
    logic        a_adv;
    logic [2:0]  dst_sel;
    logic [3:0]  merge_len;
    logic        merge_sup;

    assign words[0] = word0;
    assign words[1] = word1;
    assign words[2] = word2;
    assign words[3] = word3;
    assign words[4] = word4;
    assign words[5] = word5;
    assign words[6] = word6;

    // pipeline flow control
    assign b_adv    = !b_valid_reg || !out_stall;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_stall = !a_adv;

    // move operand fields
    assign mv_imm = (word0[13:12] == 2'd2) ? 3'd2 : 3'd1;
    assign dst_ea = {word0[8:6], word0[11:9]};

    // source lane of a move
    m68kild_ea_lane u_src_lane (
        .ea        (word0[5:0]),
        .ext       (word1),
        .imm_words (mv_imm),
        .words     (src_n)
    );

    // destination lanes, one per possible extension word position
    for (genvar g = 0; g < DST_LANES; g++)
    begin : g_dst
        m68kild_ea_lane u_dst_lane (
            .ea        (dst_ea),
            .ext       (words[g+1]),
            .imm_words (mv_imm),
            .words     (dst_n[g])
        );
    end

    // line-F classification and its effective address lane
    m68kild_linef_dec u_linef_dec (
        .op  (word0),
        .op2 (word1),
        .cls (lf_cls)
    );

    m68kild_ea_lane u_lf_lane (
        .ea        (word0[5:0]),
        .ext       (word2),
        .imm_words (lf_cls.imm),
        .words     (lf_n)
    );

    // lane stage registers
    assign a_valid_next = a_adv ? in_valid : a_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && in_valid)
        begin
            a_line_reg   <= word0[15:12];
            a_src_reg    <= src_n;
            a_lf_n_reg   <= lf_n;
            a_lf_reg     <= lf_cls;
            a_branch_reg <= flow_change(word0);
            for (int i = 0; i < DST_LANES; i++)
            begin
                a_dst_reg[i] <= dst_n[i];
            end
        end
    end

    // pick the destination lane that saw the right extension word
    always_comb
    begin
        if (a_src_reg < 3'(DST_LANES))
        begin
            dst_sel = a_dst_reg[a_src_reg];
        end
        else
        begin
            dst_sel = 3'd0;
        end
    end

    // merge lane results by opcode line
    always_comb
    begin
        merge_len = 4'd0;
        merge_sup = 1'b0;
        priority if ((a_line_reg == 4'h1) || (a_line_reg == 4'h2) || (a_line_reg == 4'h3))
        begin
            merge_len = 4'd1 + {1'b0, a_src_reg} + {1'b0, dst_sel};
            merge_sup = 1'b1;
        end
        else if (a_line_reg == 4'hf)
        begin
            merge_sup = 1'b1;
            if (a_lf_reg.fixed)
            begin
                merge_len = {2'b00, a_lf_reg.fixed_len};
            end
            else if (a_lf_reg.need_ea)
            begin
                merge_len = 4'd2 + {1'b0, a_lf_n_reg};
            end
            else
            begin
                merge_len = 4'd2;
            end
        end
        else
        begin
            merge_len = 4'd0;
            merge_sup = 1'b0;
        end
    end

    // output register
    assign b_valid_next = b_adv ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && a_valid_reg)
        begin
            b_len_reg    <= merge_len;
            b_sup_reg    <= merge_sup;
            b_branch_reg <= a_branch_reg;
        end
    end

    assign out_valid    = b_valid_reg;
    assign length_words = b_len_reg;
    assign supported    = b_sup_reg;
    assign is_branch    = b_branch_reg;

    // supported results always have a length, unsupported ones never
    a_len_sup: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_sup_reg == (b_len_reg != 4'd0)))
        else $error("length and supported flag disagree");

    // longest instruction is eleven words
    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_len_reg <= 4'd11))
        else $error("length out of range");

    // an accepted item reaches the lane stage
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> a_valid_reg)
        else $error("accepted item lost");

    // input stalls only when both stages are full and output is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid_reg && b_valid_reg && out_stall))
        else $error("input stalled without cause");

endmodule

/* rtl/core/m68kild_ea_lane.sv */
module m68kild_ea_lane
    import m68kild_pkg::*;
(
    input  logic [5:0]  ea,
    input  logic [15:0] ext,
    input  logic [2:0]  imm_words,
    output logic [2:0]  words
);

    logic [2:0] mode;
    logic [2:0] regno;
    logic [1:0] od_words;
    logic [1:0] bd_words;
    logic [2:0] idx_words;

    assign mode  = ea[5:3];
    assign regno = ea[2:0];

    // full format: extension word plus base and outer displacements
    assign od_words  = ext[1] ? (ext[0] ? 2'd2 : 2'd1) : 2'd0;
    assign bd_words  = ext[5] ? (ext[4] ? 2'd2 : 2'd1) : 2'd0;
    assign idx_words = ext[8] ? (3'd1 + {1'b0, od_words} + {1'b0, bd_words}) : 3'd1;

    // extension words by addressing mode
    always_comb
    begin
        unique case (mode)
            3'd5:
            begin
                words = 3'd1;
            end
            3'd6:
            begin
                words = idx_words;
            end
            3'd7:
            begin
                unique case (regno)
                    3'd0, 3'd2: words = 3'd1;
                    3'd1:       words = 3'd2;
                    3'd3:       words = idx_words;
                    3'd4:       words = imm_words;
                    default:    words = 3'd0;
                endcase
            end
            default:
            begin
                words = 3'd0;
            end
        endcase
    end

endmodule

/* rtl/core/m68kild_linef_dec.sv */
module m68kild_linef_dec
    import m68kild_pkg::*;
(
    input  logic [15:0] op,
    input  logic [15:0] op2,
    output lf_class_t   cls
);

    logic       f200;
    logic       arith;
    logic [2:0] fmt;
    logic [2:0] fmt_imm;
    logic [15:0] ma;
    logic [15:0] mb;

    assign f200 = (op & 16'hffc0) == 16'hf200;
    assign fmt  = op2[12:10];
    assign ma   = op2 & 16'ha07f;
    assign mb   = op2 & 16'ha07b;

    // fpu arithmetic opmode patterns
    assign arith = (ma == 16'h0018) || (mb == 16'h0058) || (ma == 16'h0022) ||
                   (mb == 16'h0062) || (ma == 16'h0038) || (ma == 16'h0020) ||
                   (mb == 16'h0060) || (ma == 16'h0001) || (ma == 16'h0003) ||
                   (ma == 16'h0014) || (ma == 16'h0000) || (mb == 16'h0040) ||
                   (ma == 16'h0023) || (mb == 16'h0063) || (ma == 16'h001a) ||
                   (mb == 16'h005a) || (ma == 16'h003a) || (ma == 16'h0004) ||
                   (mb == 16'h0041) || (ma == 16'h0028) || (mb == 16'h0068) ||
                   (ma == 16'h000e) || (ma == 16'h001d);

    // immediate size by source format
    always_comb
    begin
        unique case (fmt)
            3'd0, 3'd1: fmt_imm = 3'd2;
            3'd2, 3'd3: fmt_imm = 3'd6;
            3'd4, 3'd6: fmt_imm = 3'd1;
            3'd5:       fmt_imm = 3'd4;
            default:    fmt_imm = 3'd0;
        endcase
    end

    // opcode classes in priority order
    always_comb
    begin
        cls = '0;
        priority if (((op & 16'hfff8) == 16'hf620) && ((op2 & 16'h8fff) == 16'h8000))
        begin
            cls.fixed     = 1'b1;
            cls.fixed_len = 2'd2;
        end
        else if ((op & 16'hffe0) == 16'hf600)
        begin
            cls.fixed     = 1'b1;
            cls.fixed_len = 2'd3;
        end
        else if ((op & 16'hff00) == 16'hf400)
        begin
            cls.fixed     = 1'b1;
            cls.fixed_len = 2'd1;
        end
        else if ((op == 16'hf200) && ((op2 & 16'hfc00) == 16'h5c00))
        begin
            cls.fixed     = 1'b1;
            cls.fixed_len = 2'd2;
        end
        else if ((op & 16'hff80) == 16'hf280)
        begin
            cls.fixed     = 1'b1;
            cls.fixed_len = op[6] ? 2'd3 : 2'd2;
        end
        else if (f200 && arith)
        begin
            cls.need_ea = op2[14];
            cls.imm     = op2[14] ? fmt_imm : 3'd0;
        end
        else if (f200 && ((op2 & 16'he07f) == 16'h6000))
        begin
            cls.need_ea = 1'b1;
            cls.imm     = (fmt == 3'd7) ? 3'd6 : fmt_imm;
        end
        else if (f200 && (((op2 & 16'he3ff) == 16'ha000) || ((op2 & 16'he3ff) == 16'h8000)))
        begin
            cls.need_ea = 1'b1;
            cls.imm     = 3'd2;
        end
        else if (f200 && ((op2 & 16'hc700) == 16'hc000))
        begin
            cls.need_ea = 1'b1;
        end
        else if (((op & 16'hffc0) == 16'hf240) && ((op2 & 16'hffc0) == 16'h0000))
        begin
            cls.need_ea = 1'b1;
            cls.imm     = 3'd1;
        end
        else
        begin
            cls = '0;
        end
    end

endmodule

/* tb/m68kild_tb_pkg.sv */
package m68kild_tb_pkg;

    // the seven instruction words of one item, word 0 is the opcode
    typedef logic [6:0][15:0] insn_words_t;

    typedef struct {
        logic [3:0] len;
        logic       sup;
        logic       br;
    } decode_result_t;

    // effective address modes and mode 7 register codes
    localparam logic [2:0] EA_DISP     = 3'd5;
    localparam logic [2:0] EA_INDEX    = 3'd6;
    localparam logic [2:0] EA_SPECIAL  = 3'd7;
    localparam logic [2:0] SP_ABS_W    = 3'd0;
    localparam logic [2:0] SP_ABS_L    = 3'd1;
    localparam logic [2:0] SP_PC_DISP  = 3'd2;
    localparam logic [2:0] SP_PC_INDEX = 3'd3;
    localparam logic [2:0] SP_IMM      = 3'd4;

    // fpu source format with dynamic k-factor
    localparam logic [2:0] FMT_PACKED_DYN = 3'd7;

    // line-F opcode bases
    localparam logic [15:0] OP_FGEN       = 16'hf200;
    localparam logic [15:0] OP_FSCC       = 16'hf240;
    localparam logic [15:0] OP_FBCC       = 16'hf280;
    localparam logic [15:0] OP_CINV       = 16'hf400;
    localparam logic [15:0] OP_MOVE16     = 16'hf600;
    localparam logic [15:0] OP_MOVE16_REG = 16'hf620;

    // words added by a base or outer displacement size field
    function automatic logic [3:0] disp_size_words(logic [1:0] sz);
        return (sz == 2'd2) ? 4'd1 : (sz == 2'd3) ? 4'd2 : 4'd0;
    endfunction

    // extension words following one effective address
    function automatic logic [3:0] ea_ext_words(logic [5:0] ea, logic [15:0] ext,
                                                logic [3:0] imm_words);
        logic [2:0] mode;
        logic [2:0] rn;
        logic [3:0] n;
        mode = ea[5:3];
        rn   = ea[2:0];
        n    = 4'd0;
        if (mode == EA_DISP)
        begin
            n = 4'd1;
        end
        else if (mode == EA_INDEX || (mode == EA_SPECIAL && rn == SP_PC_INDEX))
        begin
            // full format adds displacement words, brief format is one word
            n = 4'd1;
            if (ext[8])
                n = n + disp_size_words(ext[5:4]) + disp_size_words(ext[1:0]);
        end
        else if (mode == EA_SPECIAL)
        begin
            case (rn)
                SP_ABS_W, SP_PC_DISP: n = 4'd1;
                SP_ABS_L:             n = 4'd2;
                SP_IMM:               n = imm_words;
                default:              n = 4'd0;
            endcase
        end
        return n;
    endfunction

    // immediate size in words for each fpu source format
    function automatic logic [3:0] fmt_imm_words(logic [2:0] fmt);
        case (fmt)
            3'd0, 3'd1: return 4'd2;
            3'd2, 3'd3: return 4'd6;
            3'd4, 3'd6: return 4'd1;
            3'd5:       return 4'd4;
            default:    return 4'd0;
        endcase
    endfunction

    // fpu arithmetic opmodes recognized in the command word
    function automatic logic fpu_arith_cmd(logic [15:0] op2);
        logic [15:0] a;
        logic [15:0] b;
        logic        hit;
        a   = op2 & 16'ha07f;
        b   = op2 & 16'ha07b;
        hit = 1'b0;
        case (a)
            16'h0000, 16'h0001, 16'h0003, 16'h0004, 16'h000e, 16'h0014, 16'h0018,
            16'h001a, 16'h001d, 16'h0020, 16'h0022, 16'h0023, 16'h0028, 16'h0038,
            16'h003a: hit = 1'b1;
            default: ;
        endcase
        case (b)
            16'h0040, 16'h0041, 16'h0058, 16'h005a, 16'h0060, 16'h0062, 16'h0063,
            16'h0068: hit = 1'b1;
            default: ;
        endcase
        return hit;
    endfunction

    // opcodes that branch or may redirect control flow
    function automatic logic flow_target(logic [15:0] op);
        casez (op)
            16'h007c, 16'h027c, 16'h0a7c, 16'h4afc, 16'h4e70,
            16'h4e72, 16'h4e73, 16'h4e74, 16'h4e75, 16'h4e76, 16'h4e77: return 1'b1;
            16'b0100_0000_11??_????: return 1'b1;
            16'b0100_0110_11??_????: return 1'b1;
            16'b0100_1000_0100_1???: return 1'b1;
            16'h4e4?, 16'h4e6?:      return 1'b1;
            16'b0100_1110_0111_101?: return 1'b1;
            16'b0100_1110_1???_????: return 1'b1;
            16'b0101_????_1100_1???: return 1'b1;
            16'b0110_????_????_????: return 1'b1;
            default:                 return 1'b0;
        endcase
    endfunction

    // move length: opcode, source extension, destination extension
    function automatic logic [3:0] move_words(insn_words_t w);
        logic [15:0] op;
        logic [3:0]  imm;
        logic [3:0]  len;
        op  = w[0];
        imm = (op[13:12] == 2'd2) ? 4'd2 : 4'd1;
        len = 4'd1 + ea_ext_words(op[5:0], w[1], imm);
        // destination ea has mode and register swapped
        len = len + ea_ext_words({op[8:6], op[11:9]}, w[len[2:0]], imm);
        return len;
    endfunction

    function automatic logic [3:0] linef_words(insn_words_t w);
        logic [15:0] op;
        logic [15:0] op2;
        logic [2:0]  fmt;
        logic        gen;
        logic        need_ea;
        logic [3:0]  imm;
        op      = w[0];
        op2     = w[1];
        fmt     = op2[12:10];
        gen     = (op & 16'hffc0) == OP_FGEN;
        need_ea = 1'b0;
        imm     = 4'd0;

        // fixed-length forms
        if ((op & 16'hfff8) == OP_MOVE16_REG && (op2 & 16'h8fff) == 16'h8000)
            return 4'd2;
        if ((op & 16'hffe0) == OP_MOVE16)
            return 4'd3;
        if ((op & 16'hff00) == OP_CINV)
            return 4'd1;
        if (op == OP_FGEN && op2[15:10] == 6'b010111)
            return 4'd2;
        if ((op & 16'hff80) == OP_FBCC)
            return op[6] ? 4'd3 : 4'd2;

        // general fpu forms with an effective address
        if (gen && fpu_arith_cmd(op2))
        begin
            if (op2[14])
            begin
                need_ea = 1'b1;
                imm     = fmt_imm_words(fmt);
            end
        end
        else if (gen && (op2 & 16'he07f) == 16'h6000)
        begin
            need_ea = 1'b1;
            imm     = (fmt == FMT_PACKED_DYN) ? 4'd6 : fmt_imm_words(fmt);
        end
        else if (gen && ((op2 & 16'he3ff) == 16'ha000 || (op2 & 16'he3ff) == 16'h8000))
        begin
            need_ea = 1'b1;
            imm     = 4'd2;
        end
        else if (gen && (op2 & 16'hc700) == 16'hc000)
        begin
            need_ea = 1'b1;
        end
        else if ((op & 16'hffc0) == OP_FSCC && (op2 & 16'hffc0) == 16'h0000)
        begin
            need_ea = 1'b1;
            imm     = 4'd1;
        end

        return 4'd2 + (need_ea ? ea_ext_words(op[5:0], w[2], imm) : 4'd0);
    endfunction

    function automatic decode_result_t predict_decode(insn_words_t w);
        decode_result_t r;
        r.br  = flow_target(w[0]);
        r.len = 4'd0;
        r.sup = 1'b0;
        case (w[0][15:12])
            4'h1, 4'h2, 4'h3:
            begin
                r.len = move_words(w);
                r.sup = 1'b1;
            end
            4'hf:
            begin
                r.len = linef_words(w);
                r.sup = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // expected decodes in acceptance order
    class ild_scoreboard;
        decode_result_t expected_q[$];
        int unsigned    errors;

        function new();
            errors = 0;
        endfunction

        function void note_item(insn_words_t w);
            expected_q.push_back(predict_decode(w));
        endfunction

        function void check_result(logic [3:0] len, logic sup, logic br);
            decode_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result with no item pending: length_words %0d supported %0d is_branch %0d",
                       len, sup, br);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (len !== e.len)
            begin
                $error("length_words: expected %0d, actual %0d", e.len, len);
                errors++;
            end
            if (sup !== e.sup)
            begin
                $error("supported: expected %0d, actual %0d", e.sup, sup);
                errors++;
            end
            if (br !== e.br)
            begin
                $error("is_branch: expected %0d, actual %0d", e.br, br);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

/* tb/tb_top.sv */
module tb_top;
    import m68kild_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_RANDOM = 950;
    localparam int unsigned NUM_DIRECTED = 26;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] word0 = 16'h0;
    logic [15:0] word1 = 16'h0;
    logic [15:0] word2 = 16'h0;
    logic [15:0] word3 = 16'h0;
    logic [15:0] word4 = 16'h0;
    logic [15:0] word5 = 16'h0;
    logic [15:0] word6 = 16'h0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  length_words;
    logic        supported;
    logic        is_branch;

    logic          idle_on = 1'b0;
    int unsigned   stall_left = 0;
    ild_scoreboard sb;

    m68k_instruction_length_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .word0        (word0),
        .word1        (word1),
        .word2        (word2),
        .word3        (word3),
        .word4        (word4),
        .word5        (word5),
        .word6        (word6),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .length_words (length_words),
        .supported    (supported),
        .is_branch    (is_branch)
    );

    always #4 clk = ~clk;

    // result side: random stall bursts and checking of accepted results
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(length_words, supported, is_branch);
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // random effective address, biased toward modes that carry extension words
    function automatic logic [5:0] pick_ea();
        logic [2:0] mode;
        mode = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 1) == 1)
            mode = 3'($urandom_range(5, 7));
        return {mode, 3'($urandom_range(0, 7))};
    endfunction

    // fpu arithmetic opmode, including the forms matched with bit 2 free
    function automatic logic [6:0] pick_arith_opmode();
        case ($urandom_range(0, 22))
            0:  return 7'h18;
            1:  return 7'h58;
            2:  return 7'h22;
            3:  return 7'h66;
            4:  return 7'h38;
            5:  return 7'h20;
            6:  return 7'h64;
            7:  return 7'h01;
            8:  return 7'h03;
            9:  return 7'h14;
            10: return 7'h00;
            11: return 7'h44;
            12: return 7'h23;
            13: return 7'h67;
            14: return 7'h1a;
            15: return 7'h5e;
            16: return 7'h3a;
            17: return 7'h04;
            18: return 7'h45;
            19: return 7'h28;
            20: return 7'h6c;
            21: return 7'h0e;
            default: return 7'h1d;
        endcase
    endfunction

    // random instruction window, mostly well-formed opcodes with random extensions
    function automatic insn_words_t make_insn();
        insn_words_t w;
        logic [5:0]  ea;
        logic [5:0]  dst;
        for (int i = 0; i < 7; i++)
            w[i] = 16'($urandom);
        ea  = pick_ea();
        dst = pick_ea();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4:
                w[0] = {2'b00, 2'($urandom_range(1, 3)), dst[2:0], dst[5:3], ea};
            5, 6:
            begin
                w[0] = OP_FGEN | 16'(ea);
                w[1] = (16'($urandom) & 16'h5f80) | 16'(pick_arith_opmode());
            end
            7:
            begin
                w[0] = OP_FGEN | 16'(ea);
                w[1] = 16'h6000 | (16'($urandom) & 16'h1f80);
            end
            8:
            begin
                w[0] = OP_FGEN | 16'(ea);
                w[1] = ($urandom_range(0, 1) ? 16'ha000 : 16'h8000) |
                       (16'($urandom) & 16'h1c00);
            end
            9:
            begin
                w[0] = OP_FGEN | 16'(ea);
                w[1] = 16'hc000 | (16'($urandom) & 16'h38ff);
            end
            10:
            begin
                w[0] = OP_FSCC | 16'(ea);
                if ($urandom_range(0, 3) != 0)
                    w[1] = 16'($urandom) & 16'h003f;
            end
            11:
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        w[0] = OP_MOVE16_REG | 16'($urandom_range(0, 7));
                        if ($urandom_range(0, 3) != 0)
                            w[1] = 16'h8000 | (16'($urandom) & 16'h7000);
                    end
                    1: w[0] = OP_MOVE16 | 16'($urandom_range(0, 31));
                    2: w[0] = OP_CINV | 16'($urandom_range(0, 255));
                    3:
                    begin
                        w[0] = OP_FGEN;
                        w[1] = 16'h5c00 | 16'($urandom_range(0, 1023));
                    end
                    default: w[0] = OP_FBCC | 16'($urandom_range(0, 127));
                endcase
            end
            12:
                w[0] = 16'hf000 | 16'($urandom_range(0, 4095));
            13:
            begin
                // flow-change opcodes and nearby encodings with random free bits
                case ($urandom_range(0, 5))
                    0: w[0] = 16'h6000 | 16'($urandom_range(0, 4095));
                    1: w[0] = 16'h50c8 | 16'($urandom & 16'h0f07);
                    2: w[0] = 16'h4e40 | 16'($urandom_range(0, 63));
                    3: w[0] = 16'h4e80 | 16'($urandom_range(0, 127));
                    4: w[0] = 16'h4000 | 16'($urandom & 16'h06ff);
                    default:
                        case ($urandom_range(0, 3))
                            0: w[0] = 16'h007c;
                            1: w[0] = 16'h027c;
                            2: w[0] = 16'h0a7c;
                            default: w[0] = 16'h4afc;
                        endcase
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    // directed cases: field extremes, each opcode class and the corner forms
    function automatic insn_words_t directed_insn(int k);
        insn_words_t w;
        for (int i = 0; i < 7; i++)
            w[i] = 16'($urandom);
        case (k)
            0: w = '0;
            1: w = '1;
            // move.l with full-format long displacements on both sides, longest item
            2:
            begin
                w[0] = 16'h27b3;
                w[1] = 16'h0133;
                w[6] = 16'h0133;
            end
            // brief pc-indexed source to absolute long
            3:
            begin
                w[0] = 16'h33fb;
                w[1] = 16'h0000;
            end
            // immediate destination sized like an immediate source
            4: w[0] = 16'h29fc;
            5: w[0] = 16'h19fc;
            6:
            begin
                w[0] = 16'h31b0;
                w[1] = 16'h0122;
                w[4] = 16'h0130;
            end
            7: w[0] = 16'hf000;
            8:
            begin
                w[0] = OP_FGEN;
                w[1] = 16'h5c00;
            end
            9:
            begin
                w[0] = OP_MOVE16_REG;
                w[1] = 16'h8000;
            end
            10:
            begin
                w[0] = OP_MOVE16_REG | 16'h1;
                w[1] = 16'h8001;
            end
            11: w[0] = OP_MOVE16;
            12: w[0] = OP_CINV;
            13: w[0] = OP_FBCC;
            14: w[0] = OP_FBCC | 16'h0040;
            // fmove to memory, packed with dynamic k-factor
            15:
            begin
                w[0] = OP_FGEN | 16'h003c;
                w[1] = 16'h7c00;
            end
            // arithmetic with format seven immediate adds nothing
            16:
            begin
                w[0] = OP_FGEN | 16'h003c;
                w[1] = 16'h5c22;
            end
            17:
            begin
                w[0] = OP_FGEN | 16'h003c;
                w[1] = 16'h5422;
            end
            // fmovem with immediate mode counts no immediate
            18:
            begin
                w[0] = OP_FGEN | 16'h003c;
                w[1] = 16'hc000;
            end
            19:
            begin
                w[0] = OP_FSCC | 16'h003c;
                w[1] = 16'h0000;
            end
            20:
            begin
                w[0] = OP_FGEN | 16'h003c;
                w[1] = 16'h9000;
            end
            21: w[0] = 16'h6000;
            22: w[0] = 16'h51c8;
            23: w[0] = 16'h4e75;
            24: w[0] = 16'h4e71;
            default: w[0] = 16'h007c;
        endcase
        return w;
    endfunction

    // present one item and hold it until accepted
    task automatic drive_item(insn_words_t w);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        word0    <= w[0];
        word1    <= w[1];
        word2    <= w[2];
        word3    <= w[3];
        word4    <= w[4];
        word5    <= w[5];
        word6    <= w[6];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(w);
    endtask

    // run limit
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // main sequence
    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n   <= 1'b1;
        idle_on <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < NUM_DIRECTED; k++)
            drive_item(directed_insn(k));

        // random part, quiet stretches and a quiet tail
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            idle_on <= (i < NUM_RANDOM - 150) && ((i / 80) % 4 != 3);
            drive_item(make_insn());
        end
        in_valid <= 1'b0;
        idle_on  <= 1'b0;

        // drain
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/m68kild_pkg.sv
rtl/core/m68kild_ea_lane.sv
rtl/core/m68kild_linef_dec.sv
rtl/core/m68k_instruction_length_decoder.sv
tb/m68kild_tb_pkg.sv
tb/tb_top.sv
